@@ src/packed_bitmap_row_aligner_core_assert.svh @@
// ----------------------------------------------------------------------------
// Packed bitmap row aligner assertion macros
// Shared property forms for the checker: implication now and next cycle.
// ----------------------------------------------------------------------------
`ifndef PACKED_BITMAP_ROW_ALIGNER_CORE_ASSERT_SVH
`define PACKED_BITMAP_ROW_ALIGNER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PBA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PBA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ src/pba_pkg.sv @@
// ----------------------------------------------------------------------------
// Packed bitmap row aligner package
// Phase codes, parser state and result types shared by the modules.
// ----------------------------------------------------------------------------
package pba_pkg;

	typedef enum logic [1:0] {
		PH_COLS   = 2'd0,
		PH_ROWS   = 2'd1,
		PH_PIXELS = 2'd2
	} phase_t;

	typedef struct packed {
		phase_t     phase;
		logic [7:0] cols;
		logic [7:0] rows;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] pend;
	} parse_st_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       row_end;
		logic       bitmap_end;
		logic       empty_bitmap;
	} result_t;

	typedef struct packed {
		parse_st_t  st;
		logic [2:0] pos;
		logic       done;
		logic       emit;
		result_t    res;
	} step_t;

endpackage

@@ src/packed_bitmap_row_aligner_core.sv @@
// ----------------------------------------------------------------------------
// Packed bitmap row aligner core
// Repacks a packed monochrome bitmap stream so each row starts on a byte.
// ----------------------------------------------------------------------------
// A source word is registered in the input stage, and each result word it gives
// is registered in the output register.
// A count word is read at once; a pixel word is worked on run by run, where a
// run stops at the source byte end, a row byte boundary or a row end. The next
// word enters as the last run of the current one retires.
// Reset: arst_n clears the parser to "expect column count" and empties both
// the input stage and the output register.
module packed_bitmap_row_aligner_core import pba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] src_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       row_end,
	output logic       bitmap_end,
	output logic       empty_bitmap
);

	// Input stage: the word being worked on and the next unread bit in it.
	logic       vld_s1;
	logic [7:0] byte_s1;
	logic [2:0] pos_s1;

	// Parser state carried from word to word.
	parse_st_t  st_q;

	step_t      nxt;
	logic       out_free;
	logic       advance;
	logic       in_take;
	result_t    out_res;

	// The step unit works out one run of bits per cycle. It only advances
	// when the output register can take whatever the run may produce, so a
	// run that emits nothing still waits on a full, stalled output.
	pba_step u_step (
		.byte_in (byte_s1),
		.pos     (pos_s1),
		.st      (st_q),
		.nxt     (nxt)
	);

	assign advance = vld_s1 && out_free;

	// A new word enters when the stage is empty or its last run retires now.
	assign in_stall = vld_s1 && !(advance && nxt.done);
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			pos_s1 <= '0;
		end else if (in_take) begin
			vld_s1 <= 1'b1;
			pos_s1 <= '0;
		end else if (advance) begin
			vld_s1 <= !nxt.done;
			pos_s1 <= nxt.pos;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= src_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{phase: PH_COLS, cols: 8'd0, rows: 8'd0, col: 8'd0,
				row: 8'd0, pend: 8'd0};
		end else if (advance) begin
			st_q <= nxt.st;
		end
	end

	// The output register holds a finished word for the consumer; while it is
	// full and stalled the step unit waits and the input stage holds its word.
	pba_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance && nxt.emit),
		.res       (nxt.res),
		.out_stall (out_stall),
		.free      (out_free),
		.out_valid (out_valid),
		.out_res   (out_res)
	);

	assign out_byte     = out_res.out_byte;
	assign row_end      = out_res.row_end;
	assign bitmap_end   = out_res.bitmap_end;
	assign empty_bitmap = out_res.empty_bitmap;

endmodule

@@ src/pba_step.sv @@
// ----------------------------------------------------------------------------
// Packed bitmap row aligner step unit
// Moves one run of pixel bits from the source byte into the row byte, or reads a column or row count.
// ----------------------------------------------------------------------------
module pba_step import pba_pkg::*; (
	input  logic [7:0] byte_in,
	input  logic [2:0] pos,
	input  parse_st_t  st,
	output step_t      nxt
);

	logic [3:0] avail;
	logic [3:0] room;
	logic [7:0] rem;
	logic [3:0] take_ab;
	logic [3:0] take;
	logic       rdone;
	logic       full;
	logic       last;
	logic [7:0] shifted;
	logic [7:0] mask;
	logic [7:0] merged;
	logic [3:0] pos_sum;
	logic [8:0] row_p1;

	// A run ends at the source byte end, the row byte end or the row end.
	always_comb begin
		avail   = 4'd8 - {1'b0, pos};
		room    = 4'd8 - {1'b0, st.col[2:0]};
		rem     = st.cols - st.col;
		take_ab = (avail < room) ? avail : room;
		take    = ({4'b0, take_ab} > rem) ? rem[3:0] : take_ab;
		rdone   = ({4'b0, take} == rem);
		full    = (take == room);
		row_p1  = {1'b0, st.row} + 9'd1;
		last    = rdone && (row_p1 >= {1'b0, st.rows});
		shifted = byte_in << pos;
		mask    = 8'hFF << (4'd8 - take);
		merged  = st.pend | ((shifted & mask) >> st.col[2:0]);
		pos_sum = {1'b0, pos} + take;
	end

	always_comb begin
		nxt     = '0;
		nxt.st  = st;
		nxt.pos = pos;
		case (st.phase)
			PH_ROWS: begin
				nxt.st.rows = byte_in;
				nxt.st.col  = '0;
				nxt.st.row  = '0;
				nxt.st.pend = '0;
				nxt.done    = 1'b1;
				if (byte_in == 8'd0) begin
					nxt.st.phase = PH_COLS;
					nxt.emit     = 1'b1;
					nxt.res      = '{out_byte: 8'd0, row_end: 1'b0,
						bitmap_end: 1'b1, empty_bitmap: 1'b1};
				end else begin
					nxt.st.phase = PH_PIXELS;
				end
			end
			PH_PIXELS: begin
				nxt.emit = rdone || full;
				nxt.res  = '{out_byte: merged, row_end: rdone,
					bitmap_end: last, empty_bitmap: 1'b0};
				nxt.pos  = pos_sum[2:0];
				nxt.done = pos_sum[3] || last;
				nxt.st.pend = (rdone || full) ? 8'd0 : merged;
				if (last) begin
					nxt.st.phase = PH_COLS;
					nxt.st.col   = '0;
					nxt.st.row   = '0;
				end else if (rdone) begin
					nxt.st.col = '0;
					nxt.st.row = row_p1[7:0];
				end else begin
					nxt.st.col = st.col + {4'b0, take};
				end
			end
			default: begin
				// Column count; the unused phase code is read the same way.
				nxt.st.cols = byte_in;
				nxt.st.col  = '0;
				nxt.st.row  = '0;
				nxt.st.pend = '0;
				nxt.done    = 1'b1;
				if (byte_in == 8'd0) begin
					nxt.st.phase = PH_COLS;
					nxt.emit     = 1'b1;
					nxt.res      = '{out_byte: 8'd0, row_end: 1'b0,
						bitmap_end: 1'b1, empty_bitmap: 1'b1};
				end else begin
					nxt.st.phase = PH_ROWS;
				end
			end
		endcase
	end

endmodule

@@ src/pba_out_reg.sv @@
// ----------------------------------------------------------------------------
// Packed bitmap row aligner output register
// Holds one result word until the downstream side takes it.
// ----------------------------------------------------------------------------
module pba_out_reg import pba_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    load,
	input  result_t res,
	input  logic    out_stall,
	output logic    free,
	output logic    out_valid,
	output result_t out_res
);

	logic    vld_q;
	result_t res_q;

	assign free      = !vld_q || !out_stall;
	assign out_valid = vld_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (free) begin
			vld_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

endmodule

@@ src/pba_checker.sv @@
// ----------------------------------------------------------------------------
// Packed bitmap row aligner checker
// Port level properties of the core, attached by a bind.
// ----------------------------------------------------------------------------
`include "packed_bitmap_row_aligner_core_assert.svh"

module pba_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [7:0] src_byte,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_byte,
	input logic       row_end,
	input logic       bitmap_end,
	input logic       empty_bitmap
);

	logic empty_ok;

	// An empty bitmap word is zero, closes the bitmap and ends no row.
	assign empty_ok = bitmap_end && !row_end && (out_byte == 8'd0);

	// A stalled source word stays offered and unchanged.
	`PBA_ASSERT_NEXT(a_in_hold, in_valid && in_stall, in_valid && $stable(src_byte), "src word lost")

	// A stalled result word stays offered.
	`PBA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped")

	// A stalled result word keeps its pixels.
	`PBA_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_byte), "result word moved")

	// An empty bitmap word is zero, closes the bitmap and ends no row.
	`PBA_ASSERT_NOW(a_empty_form, out_valid && empty_bitmap, empty_ok, "malformed empty word")

	// The last word of a real bitmap also ends its last row.
	`PBA_ASSERT_NOW(a_end_row, out_valid && bitmap_end && !empty_bitmap, row_end, "open row at end")

endmodule

bind packed_bitmap_row_aligner_core pba_checker u_pba_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.src_byte     (src_byte),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.out_byte     (out_byte),
	.row_end      (row_end),
	.bitmap_end   (bitmap_end),
	.empty_bitmap (empty_bitmap)
);
